>>> hdl/lcsf_pkg.sv
// Package with shared types and constants for the lock conflict scan filter.
package lcsf_pkg;

	localparam int MARK_BITS_DEF = 4096;
	localparam int FP_LANES      = 4;
	localparam int FP_W          = 12;
	localparam int ID_W          = 64;
	localparam int EPOCH_W       = 8;
	localparam int TAG_W         = 8;
	localparam int CNT_W         = 3;
	localparam int LANE_W        = $clog2(FP_LANES);

	localparam logic [7:0] REG_HIGH_WATER = 8'd0;
	localparam logic [7:0] REG_MAX_SCAN   = 8'd1;

	typedef enum logic [2:0] {
		V_PENDING   = 3'd0,
		V_EXECUTE   = 3'd1,
		V_CONFLICT  = 3'd2,
		V_NOT_READY = 3'd3,
		V_GLOBAL    = 3'd4,
		V_INACTIVE  = 3'd5
	} verdict_t;

	typedef struct packed {
		logic             begin_scan;
		logic [15:0]      queue_length;
		logic [ID_W-1:0]  tx_id;
		logic             tx_last;
		logic             tx_ready;
		logic             tx_global;
		logic             tx_is_read;
		logic [CNT_W-1:0] fp_count;
		logic [FP_W-1:0]  fp_lane0;
		logic [FP_W-1:0]  fp_lane1;
		logic [FP_W-1:0]  fp_lane2;
		logic [FP_W-1:0]  fp_lane3;
	} item_t;

	typedef struct packed {
		logic [2:0]      verdict;
		logic [ID_W-1:0] committed_id;
	} result_t;

	// Write command broadcast to every lane's copy of the mark stores.
	typedef struct packed {
		logic                     tag_we;
		logic                     read_we;
		logic [EPOCH_W+TAG_W-1:0] tag;
		logic [EPOCH_W-1:0]       epoch;
	} mark_wr_t;

	// What one lane found for its fingerprint.
	typedef struct packed {
		logic conflict;
		logic need_write;
	} lane_res_t;

endpackage

>>> hdl/lcsf_lane.sv
// One lane: a private copy of both mark stores and the conflict check for one fingerprint.
module lcsf_lane import lcsf_pkg::*; #(
	parameter int MARK_BITS = MARK_BITS_DEF,
	parameter int IDX_W     = $clog2(MARK_BITS)
) (
	input  logic                     clk,
	input  logic [IDX_W-1:0]         rd_addr,
	input  logic [IDX_W-1:0]         wr_addr,
	input  mark_wr_t                 wr,
	input  logic [EPOCH_W-1:0]       epoch,
	input  logic [TAG_W-1:0]         tag,
	input  logic                     is_read,
	output lane_res_t                res
);

	logic [EPOCH_W+TAG_W-1:0] tag_mem [MARK_BITS];
	logic [EPOCH_W-1:0]       rd_mem  [MARK_BITS];
	logic [EPOCH_W+TAG_W-1:0] tag_rd_q;
	logic [EPOCH_W-1:0]       ep_rd_q;
	logic                     wlive;
	logic                     rlive;

	always_ff @(posedge clk) begin
		if (wr.tag_we) begin
			tag_mem[wr_addr] <= wr.tag;
		end
		if (wr.read_we) begin
			rd_mem[wr_addr] <= wr.epoch;
		end
		tag_rd_q <= tag_mem[rd_addr];
		ep_rd_q  <= rd_mem[rd_addr];
	end

	always_comb begin
		wlive = (tag_rd_q[EPOCH_W+TAG_W-1:TAG_W] == epoch) && (tag_rd_q[TAG_W-1:0] != tag);
		rlive = (ep_rd_q == epoch);
		res.conflict   = wlive || (!is_read && rlive);
		res.need_write = (tag_rd_q[EPOCH_W+TAG_W-1:TAG_W] != epoch);
	end

endmodule

>>> hdl/lock_conflict_scan_filter_top.sv
// Top level of the lock conflict scan filter: control sequencer, lanes and merge.
//
// Usage: each chunk of fingerprints is offered on item with start; it is
// transferred at a clock edge where start is high and busy is low. Exactly one
// result comes back per chunk on result, marked by done for one cycle; the
// receiver cannot hold it off, so no backpressure exists on that side.
// Steps: a chunk that is ignored (scan inactive or limit reached) or that
// belongs to a global transaction gets its result straight from the pass
// evaluation. A scanned chunk with n valid fingerprints goes through the
// pass evaluation, while the lane memory reads are registered, then the
// parallel check and merge, n mark writes (one shared write port per lane
// copy), and the forming of the verdict. One chunk is worked on at a time;
// busy stays high until its result is out.
// After reset the mark stores are swept to zero, one entry per cycle, over
// all MARK_BITS entries (4096 by default) with busy high. The same sweep runs
// when the scan epoch wraps, before the chunk that opened the pass is worked.
// Configuration writes on cfg_valid/cfg_ready are always taken and should
// only be issued while the block is idle.
module lock_conflict_scan_filter_top import lcsf_pkg::*; #(
	parameter int MARK_BITS = MARK_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	output logic       done,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IDX_W = $clog2(MARK_BITS);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_EVAL, ST_CHECK, ST_WRITE, ST_FIN
	} state_t;

	state_t                state_q;
	item_t                 item_q;
	logic [15:0]           high_water_q;
	logic [7:0]            max_scan_q;
	logic [EPOCH_W-1:0]    epoch_q;
	logic                  active_q;
	logic [7:0]            scanned_q;
	logic                  conflict_q;
	logic [ID_W-1:0]       committed_q;
	logic [IDX_W-1:0]      clr_q;
	logic                  clr_ret_q;
	logic [LANE_W-1:0]     wl_q;
	logic [FP_LANES-1:0]   needw_q;
	logic                  done_q;
	result_t               result_q;

	logic [CNT_W-1:0]      cnt;
	logic [FP_W-1:0]       fp [FP_LANES];
	logic [IDX_W-1:0]      addr [FP_LANES];
	logic [IDX_W-1:0]      wr_addr;
	mark_wr_t              wr;
	lane_res_t             lres [FP_LANES];
	logic                  any_conf;
	logic [FP_LANES-1:0]   nw;
	logic [TAG_W-1:0]      tag;
	logic [CNT_W-1:0]      last_lane;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign tag       = scanned_q + 8'd1;

	always_comb begin
		cnt = (item_q.fp_count > CNT_W'(FP_LANES)) ? CNT_W'(FP_LANES) : item_q.fp_count;
		last_lane = cnt - CNT_W'(1);
		fp[0] = item_q.fp_lane0;
		fp[1] = item_q.fp_lane1;
		fp[2] = item_q.fp_lane2;
		fp[3] = item_q.fp_lane3;
		for (int l = 0; l < FP_LANES; l++) begin
			addr[l] = IDX_W'({20'd0, fp[l]});
		end
	end

	// Write port shared by all lane copies: sweep during clearing, else the current lane.
	always_comb begin
		wr = '0;
		wr_addr = addr[wl_q];
		if (state_q == ST_CLEAR) begin
			wr_addr    = clr_q;
			wr.tag_we  = 1'b1;
			wr.read_we = 1'b1;
		end else if (state_q == ST_WRITE) begin
			wr.tag     = {epoch_q, tag};
			wr.epoch   = epoch_q;
			wr.read_we = item_q.tx_is_read;
			wr.tag_we  = !item_q.tx_is_read && needw_q[wl_q];
		end
	end

	for (genvar g = 0; g < FP_LANES; g++) begin : g_lane
		lcsf_lane #(.MARK_BITS(MARK_BITS), .IDX_W(IDX_W)) u_lane (
			.clk     (clk),
			.rd_addr (addr[g]),
			.wr_addr (wr_addr),
			.wr      (wr),
			.epoch   (epoch_q),
			.tag     (tag),
			.is_read (item_q.tx_is_read),
			.res     (lres[g])
		);
	end

	// Merge stage: only lanes below the valid count take part.
	always_comb begin
		any_conf = 1'b0;
		for (int l = 0; l < FP_LANES; l++) begin
			nw[l] = lres[l].need_write;
			if (CNT_W'(l) < cnt && lres[l].conflict) begin
				any_conf = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
		end
		if (state_q == ST_CHECK) begin
			needw_q <= nw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			high_water_q <= 16'd64;
			max_scan_q   <= 8'd32;
			epoch_q      <= EPOCH_W'(1);
			active_q     <= 1'b0;
			scanned_q    <= '0;
			conflict_q   <= 1'b0;
			committed_q  <= '0;
			clr_q        <= '0;
			clr_ret_q    <= 1'b0;
			wl_q         <= '0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == REG_HIGH_WATER) begin
					high_water_q <= cfg_data[15:0];
				end else if (cfg_index == REG_MAX_SCAN) begin
					max_scan_q <= cfg_data[7:0];
				end
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(MARK_BITS - 1)) begin
						state_q <= clr_ret_q ? ST_EVAL : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EVAL;
						if (item.begin_scan) begin
							scanned_q  <= '0;
							conflict_q <= 1'b0;
							if (item.queue_length > high_water_q) begin
								active_q <= 1'b1;
								if (epoch_q == '1) begin
									// Epoch wrap: sweep the stores before working the chunk.
									epoch_q   <= EPOCH_W'(1);
									clr_q     <= '0;
									clr_ret_q <= 1'b1;
									state_q   <= ST_CLEAR;
								end else begin
									epoch_q <= epoch_q + EPOCH_W'(1);
								end
							end else begin
								active_q <= 1'b0;
							end
						end
					end
				end
				ST_EVAL: begin
					if (!active_q || scanned_q >= max_scan_q) begin
						active_q     <= 1'b0;
						done_q       <= 1'b1;
						result_q     <= '{verdict: V_INACTIVE, committed_id: committed_q};
						state_q      <= ST_IDLE;
					end else if (item_q.tx_global) begin
						done_q   <= 1'b1;
						result_q <= '{verdict: item_q.tx_last ? V_GLOBAL : V_PENDING,
							committed_id: committed_q};
						if (item_q.tx_last) begin
							scanned_q  <= scanned_q + 8'd1;
							conflict_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					conflict_q <= conflict_q | any_conf;
					wl_q       <= '0;
					state_q    <= (cnt == '0) ? ST_FIN : ST_WRITE;
				end
				ST_WRITE: begin
					wl_q <= wl_q + LANE_W'(1);
					if (CNT_W'(wl_q) == last_lane) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (!item_q.tx_last) begin
						result_q <= '{verdict: V_PENDING, committed_id: committed_q};
					end else if (!item_q.tx_ready) begin
						result_q <= '{verdict: V_NOT_READY, committed_id: committed_q};
					end else if (conflict_q) begin
						result_q <= '{verdict: V_CONFLICT, committed_id: committed_q};
					end else if (item_q.tx_id > committed_q) begin
						committed_q <= item_q.tx_id;
						result_q    <= '{verdict: V_EXECUTE, committed_id: item_q.tx_id};
					end else begin
						result_q <= '{verdict: V_EXECUTE, committed_id: committed_q};
					end
					if (item_q.tx_last) begin
						scanned_q  <= scanned_q + 8'd1;
						conflict_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
